// ===== rtl/core/tint_pkg.sv =====
package tint_pkg;

  localparam int TableDepth = 1024;
  localparam int AddrW = 10;
  localparam int CountW = 11;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusRange = 2'd1;
  localparam logic [1:0] StatusZero = 2'd2;

  localparam logic OpLoad = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [9:0]  entry_index;
    logic [31:0] time_value;
    logic [31:0] entry_density;
    logic [31:0] entry_velocity;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_density;
    logic [31:0] out_velocity;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle, StRdEnds, StWaitEnds, StChkEnds, StSearch, StSearchWait, StRdPair,
    StWaitPair, StChkPair, StDiv, StMulLo, StMulHi, StSum, StOut
  } state_t;

  typedef struct packed {
    logic       rd_en;
    logic [AddrW-1:0] rd_a;
    logic [AddrW-1:0] rd_b;
  } mem_rd_t;

  typedef struct packed {
    logic [31:0] time_a;
    logic [31:0] time_b;
    logic [31:0] dens_a;
    logic [31:0] dens_b;
    logic [31:0] vel_a;
    logic [31:0] vel_b;
  } mem_data_t;

endpackage

// ===== rtl/core/tint_table.sv =====
module tint_table (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [tint_pkg::AddrW-1:0] wr_addr,
  input  logic [31:0]               wr_time,
  input  logic [31:0]               wr_dens,
  input  logic [31:0]               wr_vel,
  input  tint_pkg::mem_rd_t         rd,
  output tint_pkg::mem_data_t       rdata
);

  logic [31:0] times [tint_pkg::TableDepth];
  logic [31:0] denss [tint_pkg::TableDepth];
  logic [31:0] vels  [tint_pkg::TableDepth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      times[wr_addr] <= wr_time;
      denss[wr_addr] <= wr_dens;
      vels[wr_addr]  <= wr_vel;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.rd_en) begin
      rdata.time_a <= times[rd.rd_a];
      rdata.time_b <= times[rd.rd_b];
      rdata.dens_a <= denss[rd.rd_a];
      rdata.dens_b <= denss[rd.rd_b];
      rdata.vel_a  <= vels[rd.rd_a];
      rdata.vel_b  <= vels[rd.rd_b];
    end
  end

endmodule

// ===== rtl/core/tint_div.sv =====
module tint_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [16:0] quotient
);

  logic [47:0] rem;
  logic [47:0] quo;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [48:0] trial;

  assign trial = {rem[47:0], quo[47]} - {17'd0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[48]) begin
        rem <= trial[47:0];
        quo <= {quo[46:0], 1'b1};
      end else begin
        rem <= {rem[46:0], quo[47]};
        quo <= {quo[46:0], 1'b0};
      end
    end
  end

  assign quotient = (quo[47:17] != '0) ? 17'h10000 : quo[16:0];

endmodule

// ===== rtl/core/table_interpolator_top.sv =====
// table piecewise-linear interpolator
// in channel (in_valid/in_ready, in_item) carries load and query items;
// out channel (out_valid/out_ready, out_item) returns one result per item.
// a load writes one row and its all-zero result is ready the next cycle;
// loads can be taken one per cycle while the receiver keeps up.
// a query reads the end rows, makes s = ceil(log2(n - 1)) search reads,
// reads the bracketing pair, runs a 48-step restoring divider for the
// fraction, then multiplies, sums and registers the result; the divider
// and the search read loop take most of a query's time.
// a query outside the table range skips the search, and one whose pair
// times do not increase skips the divide.
// one item is in work at a time; in_ready is low until its result has
// been placed in the output register.
// the result register holds until out_ready; a stalled receiver blocks
// the next item.
// cfg_valid/cfg_ready write entry_count at any time; a query uses the count
// in force when it was accepted.
// reset (rst, synchronous) sets entry_count to 2 and empties the output;
// table contents are undefined until loaded.
module table_interpolator_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tint_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output tint_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [10:0]         cfg_data
);

  tint_pkg::state_t state, state_next;
  tint_pkg::mem_rd_t   rd;
  tint_pkg::mem_data_t rdata;

  logic [10:0] entry_count;
  logic [10:0] n_used;
  logic [31:0] t_q;
  logic [10:0] lo, hi;
  logic [10:0] mid;
  logic [31:0] dens_lo, dens_hi, vel_lo, vel_hi;
  logic [16:0] u;
  logic [63:0] prod_d;
  logic signed [63:0] prod_v;
  logic [63:0] acc_d;
  logic signed [63:0] acc_v;
  logic        div_start, div_done;
  logic [16:0] div_q;
  logic [31:0] dt;
  logic        res_valid;
  logic [1:0]  res_status;
  logic        load_fire;
  logic        out_free;

  assign out_free  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;
  assign in_ready  = (state == tint_pkg::StIdle) && out_free;
  assign load_fire = in_valid && in_ready && (in_item.operation == tint_pkg::OpLoad);

  assign n_used = (entry_count < 11'd2) ? 11'd2 :
                  (entry_count > 11'(tint_pkg::TableDepth)) ? 11'(tint_pkg::TableDepth) :
                  entry_count;
  assign mid = 11'((12'(lo) + 12'(hi)) >> 1);

  tint_table u_table (
    .clk     (clk),
    .wr_en   (load_fire),
    .wr_addr (in_item.entry_index),
    .wr_time (in_item.time_value),
    .wr_dens (in_item.entry_density),
    .wr_vel  (in_item.entry_velocity),
    .rd      (rd),
    .rdata   (rdata)
  );

  assign dt = rdata.time_b - rdata.time_a;

  tint_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({t_q - rdata.time_a, 16'd0}),
    .divisor  (dt),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      tint_pkg::StIdle: begin
        if (in_valid && in_ready && in_item.operation == tint_pkg::OpQuery) begin
          state_next = tint_pkg::StRdEnds;
        end
      end
      tint_pkg::StRdEnds:   state_next = tint_pkg::StWaitEnds;
      tint_pkg::StWaitEnds: state_next = tint_pkg::StChkEnds;
      tint_pkg::StChkEnds: begin
        if (t_q < rdata.time_a || t_q > rdata.time_b) state_next = tint_pkg::StOut;
        else state_next = tint_pkg::StSearch;
      end
      tint_pkg::StSearch: begin
        if (hi - lo > 11'd1) state_next = tint_pkg::StSearchWait;
        else state_next = tint_pkg::StWaitPair;
      end
      tint_pkg::StSearchWait: state_next = tint_pkg::StSearch;
      tint_pkg::StRdPair:     state_next = tint_pkg::StWaitPair;
      tint_pkg::StWaitPair:   state_next = tint_pkg::StChkPair;
      tint_pkg::StChkPair: begin
        if (rdata.time_b <= rdata.time_a) state_next = tint_pkg::StOut;
        else state_next = tint_pkg::StDiv;
      end
      tint_pkg::StDiv:   if (div_done) state_next = tint_pkg::StMulLo;
      tint_pkg::StMulLo: state_next = tint_pkg::StMulHi;
      tint_pkg::StMulHi: state_next = tint_pkg::StSum;
      tint_pkg::StSum:   state_next = tint_pkg::StOut;
      tint_pkg::StOut:   if (out_free) state_next = tint_pkg::StIdle;
      default:           state_next = tint_pkg::StIdle;
    endcase
  end

  always_comb begin
    rd.rd_en  = 1'b0;
    rd.rd_a   = '0;
    rd.rd_b   = '0;
    div_start = 1'b0;
    unique case (state)
      tint_pkg::StRdEnds: begin
        rd.rd_en = 1'b1;
        rd.rd_a  = '0;
        rd.rd_b  = 10'(hi);
      end
      tint_pkg::StSearch: begin
        rd.rd_en = 1'b1;
        if (hi - lo > 11'd1) begin
          rd.rd_a = 10'(mid);
          rd.rd_b = 10'(mid);
        end else begin
          rd.rd_a = 10'(lo);
          rd.rd_b = 10'(hi);
        end
      end
      tint_pkg::StChkPair: div_start = (rdata.time_b > rdata.time_a);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= tint_pkg::StIdle;
      entry_count <= 11'd2;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) entry_count <= cfg_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (load_fire) out_valid <= 1'b1;
      if (state == tint_pkg::StOut && out_free) out_valid <= 1'b1;
    end
  end

  assign res_valid = (state == tint_pkg::StOut) && out_free;

  always_ff @(posedge clk) begin
    unique case (state)
      tint_pkg::StIdle: begin
        t_q <= in_item.time_value;
        lo  <= '0;
        hi  <= n_used - 11'd1;
        res_status <= tint_pkg::StatusOk;
        acc_d <= '0;
        acc_v <= '0;
      end
      tint_pkg::StChkEnds: begin
        if (t_q < rdata.time_a || t_q > rdata.time_b) res_status <= tint_pkg::StatusRange;
      end
      tint_pkg::StSearchWait: ;
      tint_pkg::StSearch: ;
      tint_pkg::StChkPair: begin
        dens_lo <= rdata.dens_a;
        dens_hi <= rdata.dens_b;
        vel_lo  <= rdata.vel_a;
        vel_hi  <= rdata.vel_b;
        if (rdata.time_b <= rdata.time_a) res_status <= tint_pkg::StatusZero;
      end
      tint_pkg::StDiv: u <= div_q;
      tint_pkg::StMulLo: begin
        prod_d <= 64'(17'h10000 - u) * 64'(dens_lo);
        prod_v <= $signed({47'd0, 17'h10000 - u}) * 64'(signed'(vel_lo));
      end
      tint_pkg::StMulHi: begin
        acc_d  <= prod_d;
        acc_v  <= prod_v;
        prod_d <= 64'(u) * 64'(dens_hi);
        prod_v <= $signed({47'd0, u}) * 64'(signed'(vel_hi));
      end
      tint_pkg::StSum: begin
        acc_d <= acc_d + prod_d + 64'd32768;
        acc_v <= acc_v + prod_v + 64'sd32768;
      end
      default: ;
    endcase
    if (state == tint_pkg::StSearchWait) begin
      if (t_q < rdata.time_a) hi <= mid;
      else lo <= mid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_fire) begin
      out_item <= '0;
    end else if (res_valid) begin
      out_item.status <= res_status;
      if (res_status == tint_pkg::StatusOk) begin
        out_item.out_density  <= acc_d[47:16];
        out_item.out_velocity <= acc_v[47:16];
      end else begin
        out_item.out_density  <= '0;
        out_item.out_velocity <= '0;
      end
    end
  end

  a_in_when_busy: assert property (@(posedge clk) disable iff (rst)
    (state != tint_pkg::StIdle) |-> !in_ready) else $error("item taken while busy");
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == tint_pkg::StDiv)) else $error("divider done outside divide");
  a_search_order: assert property (@(posedge clk) disable iff (rst)
    (state == tint_pkg::StSearch) |-> (lo < hi)) else $error("search bounds crossed");

endmodule
